/* rtl/core/ssrsg_pkg.sv */
`default_nettype none

package ssrsg_pkg;

  // segment counters and indexes
  localparam int SEG_CNT_W = 5;

  // item kinds carried on in_tuser
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_START = 2'd2,
    KIND_STOP  = 2'd3
  } kind_e;

  // motion state, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_ACCEL    = 5'b00010,
    MODE_CONSTANT = 5'b00100,
    MODE_CRUISE   = 5'b01000,
    MODE_DECEL    = 5'b10000
  } mode_e;

  // reported motion state codes
  localparam logic [2:0] STATE_IDLE     = 3'd0;
  localparam logic [2:0] STATE_ACCEL    = 3'd1;
  localparam logic [2:0] STATE_CONSTANT = 3'd2;
  localparam logic [2:0] STATE_CRUISE   = 3'd3;
  localparam logic [2:0] STATE_DECEL    = 3'd4;

  // event codes
  localparam logic [1:0] EV_MOVE_DONE = 2'd0;
  localparam logic [1:0] EV_LIMIT     = 2'd1;
  localparam logic [1:0] EV_SPEED     = 2'd2;

  // configuration register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_DIR_REVERSE = 2'd0,
    REG_LIMITS_EN   = 2'd1,
    REG_LIMIT_LOW   = 2'd2,
    REG_LIMIT_HIGH  = 2'd3
  } reg_idx_e;

  // one ramp segment table entry
  typedef struct packed {
    logic [31:0] steps;
    logic [31:0] increment;
    logic [31:0] start_interval;
  } seg_t;

  function automatic logic [2:0] mode_code(input mode_e m);
    logic [2:0] c;
    c = STATE_IDLE;
    unique case (m)
      MODE_IDLE:     c = STATE_IDLE;
      MODE_ACCEL:    c = STATE_ACCEL;
      MODE_CONSTANT: c = STATE_CONSTANT;
      MODE_CRUISE:   c = STATE_CRUISE;
      MODE_DECEL:    c = STATE_DECEL;
      default:       c = STATE_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ssrsg_ram.sv */
`default_nettype none

module ssrsg_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/stepper_segment_ramp_step_generator.sv */
// timing: an input transfer is registered in the input register, worked on from there,
//   and its result is held in the result register and offered on out_
// throughput: one item per cycle while out_ is not back-pressured
// reset: synchronous active-low rst_n clears valids, motion state and counters and
//   returns the config registers to their defaults; the segment table holds
//   garbage until written
`default_nettype none

module stepper_segment_ramp_step_generator
  import ssrsg_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // slot[3:0], seg_start_interval[35:4], seg_increment[67:36],
  // seg_len[99:68], segment_total[104:100], start_decel[105],
  // move_mode[106], move_target[138:107], cruise_interval[170:139], zero pad
  input  wire logic [175:0] in_tdata,
  // kind[1:0]
  input  wire logic [1:0]   in_tuser,
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // step_pulse[0], position[32:1], next_interval[64:33], motion_state[67:65],
  // event_valid[68], event_code[70:69], zero pad
  output logic [71:0]       out_tdata,
  // configuration port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SEG_W = $bits(seg_t);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic        dir_rev_r;
  logic        lim_en_r;
  logic [31:0] lim_lo_r;
  logic [31:0] lim_hi_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_rev_r <= 1'b0;
      lim_en_r  <= 1'b0;
      lim_lo_r  <= 32'h8000_0000;
      lim_hi_r  <= 32'h7fff_ffff;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(cfg_paddr[3:2]))
        REG_DIR_REVERSE: dir_rev_r <= cfg_pwdata[0];
        REG_LIMITS_EN:   lim_en_r  <= cfg_pwdata[0];
        REG_LIMIT_LOW:   lim_lo_r  <= cfg_pwdata;
        REG_LIMIT_HIGH:  lim_hi_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx_e'(cfg_paddr[3:2]))
      REG_DIR_REVERSE: cfg_prdata = {31'd0, dir_rev_r};
      REG_LIMITS_EN:   cfg_prdata = {31'd0, lim_en_r};
      REG_LIMIT_LOW:   cfg_prdata = lim_lo_r;
      REG_LIMIT_HIGH:  cfg_prdata = lim_hi_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input register and handshake
  // ---------------------------------------------------------------------------
  logic          in_v_r;
  kind_e         kind_r;
  logic [170:0]  in_data_r;
  logic          out_v_r;
  logic [71:0]   out_data_r;
  logic          proc;

  // an item moves into the result register whenever that register is free
  // or being drained; the input register refills in the same cycle
  assign proc      = in_v_r & (~out_v_r | out_tready);
  assign in_tready = ~in_v_r | proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r    <= kind_e'(in_tuser);
      in_data_r <= in_tdata[170:0];
    end
  end

  // field unpack
  logic [3:0]           f_slot;
  seg_t                 f_seg;
  logic [SEG_CNT_W-1:0] f_total;
  logic                 f_decel;
  logic                 f_move;
  logic [31:0]          f_target;
  logic [31:0]          f_cruise;

  assign f_slot               = in_data_r[3:0];
  assign f_seg.start_interval = in_data_r[35:4];
  assign f_seg.increment      = in_data_r[67:36];
  assign f_seg.steps          = in_data_r[99:68];
  assign f_total              = in_data_r[104:100];
  assign f_decel              = in_data_r[105];
  assign f_move               = in_data_r[106];
  assign f_target             = in_data_r[138:107];
  assign f_cruise             = in_data_r[170:139];

  // ---------------------------------------------------------------------------
  // segment table: ram holds every entry, entry 0 also lives in a shadow
  // register so a start can load it at once. the ram always reads the entry
  // after the current segment, so a chain has it ready; a write to that
  // entry in the previous cycle is forwarded around the read-first ram.
  // ---------------------------------------------------------------------------
  logic                 tbl_we;
  logic [AW-1:0]        rd_addr;
  seg_t                 ram_q;
  seg_t                 seg0_r;
  seg_t                 wr_seg_r;
  logic                 wr_hit_r;
  seg_t                 nxt_seg;
  logic [SEG_CNT_W-1:0] idx_r;
  logic [SEG_CNT_W-1:0] idx_nxt;
  logic [SEG_CNT_W:0]   rd_idx;

  assign tbl_we  = proc && (kind_r == KIND_WRITE) && (32'(f_slot) < MAX_SEGMENTS);
  assign rd_idx  = {1'b0, (proc ? idx_nxt : idx_r)} + 1'b1;
  assign rd_addr = AW'(rd_idx);
  assign nxt_seg = wr_hit_r ? wr_seg_r : ram_q;

  ssrsg_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(f_slot)),
    .wdata (f_seg),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_hit_r <= 1'b0;
    end else begin
      wr_hit_r <= tbl_we && (AW'(f_slot) == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    wr_seg_r <= f_seg;
    if (tbl_we && f_slot == 4'd0) begin
      seg0_r <= f_seg;
    end
  end

  // ---------------------------------------------------------------------------
  // motion state
  // ---------------------------------------------------------------------------
  logic [31:0]          pos_r,    pos_nxt;
  logic [31:0]          cur_r,    cur_nxt;
  logic [31:0]          inc_r,    inc_nxt;
  logic [31:0]          steps_r,  steps_nxt;
  logic [SEG_CNT_W-1:0] segs_r,   segs_nxt;
  mode_e                mode_r,   mode_nxt;
  logic                 pend_r,   pend_nxt;
  logic [31:0]          tgt_r,    tgt_nxt;
  logic [31:0]          cruise_r, cruise_nxt;

  logic                 pulse;
  logic                 ev_v;
  logic [1:0]           ev_c;
  logic [31:0]          pos_step;
  logic [SEG_CNT_W-1:0] idx_inc;
  logic                 reached;
  logic                 out_lim;
  logic                 total_ok;

  assign pos_step = pos_r + (dir_rev_r ? 32'hffff_ffff : 32'd1);
  assign idx_inc  = idx_r + 1'b1;
  assign reached  = dir_rev_r ? ($signed(pos_step) <= $signed(tgt_r))
                              : ($signed(pos_step) >= $signed(tgt_r));
  assign out_lim  = ($signed(pos_step) <= $signed(lim_lo_r)) ||
                    ($signed(pos_step) >= $signed(lim_hi_r));
  assign total_ok = (f_total != '0) && (32'(f_total) <= MAX_SEGMENTS);

  always_comb begin
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    inc_nxt    = inc_r;
    steps_nxt  = steps_r;
    idx_nxt    = idx_r;
    segs_nxt   = segs_r;
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    tgt_nxt    = tgt_r;
    cruise_nxt = cruise_r;
    pulse      = 1'b0;
    ev_v       = 1'b0;
    ev_c       = EV_MOVE_DONE;
    case (kind_r)
      KIND_TICK: begin
        // no step while idle or with a zero interval
        if (mode_r != MODE_IDLE && cur_r != '0) begin
          pulse   = 1'b1;
          pos_nxt = pos_step;
          if (pend_r && reached) begin
            pend_nxt = 1'b0;
            mode_nxt = MODE_IDLE;
            cur_nxt  = '0;
            ev_v     = 1'b1;
            ev_c     = EV_MOVE_DONE;
          end else if (lim_en_r && !pend_r && out_lim) begin
            mode_nxt = MODE_IDLE;
            cur_nxt  = '0;
            ev_v     = 1'b1;
            ev_c     = EV_LIMIT;
          end else if (steps_r != '0) begin
            cur_nxt   = cur_r + inc_r;
            steps_nxt = steps_r - 32'd1;
            if (steps_r == 32'd1) begin
              if (idx_inc < segs_r) begin
                // chain into the next segment
                idx_nxt   = idx_inc;
                cur_nxt   = nxt_seg.start_interval;
                inc_nxt   = nxt_seg.increment;
                steps_nxt = nxt_seg.steps;
              end else begin
                // ramp finished
                segs_nxt  = '0;
                idx_nxt   = '0;
                steps_nxt = '0;
                inc_nxt   = '0;
                if (pend_r) begin
                  mode_nxt = MODE_CRUISE;
                  cur_nxt  = cruise_r;
                end else if (mode_r == MODE_DECEL) begin
                  mode_nxt = MODE_IDLE;
                  cur_nxt  = '0;
                end else begin
                  mode_nxt = MODE_CONSTANT;
                  ev_v     = 1'b1;
                  ev_c     = EV_SPEED;
                end
              end
            end
          end
        end
      end
      KIND_WRITE: begin
        // table write only
      end
      KIND_START: begin
        if (total_ok) begin
          segs_nxt   = f_total;
          idx_nxt    = '0;
          cur_nxt    = seg0_r.start_interval;
          inc_nxt    = seg0_r.increment;
          steps_nxt  = seg0_r.steps;
          mode_nxt   = f_decel ? MODE_DECEL : MODE_ACCEL;
          pend_nxt   = f_move;
          tgt_nxt    = f_target;
          cruise_nxt = f_cruise;
        end
      end
      KIND_STOP: begin
        mode_nxt  = MODE_IDLE;
        cur_nxt   = '0;
        steps_nxt = '0;
        segs_nxt  = '0;
        pend_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      cur_r    <= '0;
      inc_r    <= '0;
      steps_r  <= '0;
      idx_r    <= '0;
      segs_r   <= '0;
      mode_r   <= MODE_IDLE;
      pend_r   <= 1'b0;
      tgt_r    <= '0;
      cruise_r <= '0;
    end else if (proc) begin
      pos_r    <= pos_nxt;
      cur_r    <= cur_nxt;
      inc_r    <= inc_nxt;
      steps_r  <= steps_nxt;
      idx_r    <= idx_nxt;
      segs_r   <= segs_nxt;
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      tgt_r    <= tgt_nxt;
      cruise_r <= cruise_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r <= {1'b0, ev_c, ev_v, mode_code(mode_nxt), cur_nxt, pos_nxt, pulse};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an idle axis never keeps a running interval
  a_idle_no_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (cur_r == '0))
    else $error("idle with nonzero interval");

  // no segments in use means no steps left in the ramp
  a_no_segs_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (segs_r == '0) |-> (steps_r == '0))
    else $error("steps left with no active segments");

  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_v_r && !out_tready && in_v_r))
    else $error("input stalled without output back-pressure");

  // a processed stop always reports idle and a zero interval
  a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && kind_r == KIND_STOP) |=>
      (out_data_r[67:65] == STATE_IDLE && out_data_r[64:33] == '0 && !out_data_r[68]))
    else $error("stop did not halt");

endmodule

`default_nettype wire
